@@ rtl/serial_set_time_of_day_clock_core_macros.svh @@
// Assertion macros for the serial-set time-of-day clock.
// The including module must provide i_clk and i_rst_n. No other dependencies.
`ifndef SERIAL_SET_TIME_OF_DAY_CLOCK_CORE_MACROS_SVH
`define SERIAL_SET_TIME_OF_DAY_CLOCK_CORE_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define SSTOD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted
`define SSTOD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sstod_pkg.sv @@
// Shared types, constants and helper functions for the serial-set time-of-day clock.
// No dependencies.
package sstod_pkg;

    // Item kind carried on the input tuser
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_CHAR = 1'b1;

    // Characters recognised by the time entry
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Wrap limits and display-mode phase
    localparam logic [6:0] SEC_LIMIT   = 7'd60;
    localparam logic [6:0] MIN_LIMIT   = 7'd60;
    localparam logic [6:0] HOUR_LIMIT  = 7'd24;
    localparam logic [6:0] DIGIT_LIMIT = 7'd10;
    localparam logic [4:0] PHASE_LIMIT = 5'd20;
    localparam logic [4:0] PHASE_FLIP  = 5'd10;

    // Values after reset
    localparam logic [6:0] HOUR_RESET = 7'd12;
    localparam logic [6:0] MIN_RESET  = 7'd58;
    localparam logic [6:0] SEC_RESET  = 7'd50;

    // Field selected for digit entry
    typedef enum logic [1:0] {
        FIELD_HOUR = 2'd0,
        FIELD_MIN  = 2'd1,
        FIELD_SEC  = 2'd2
    } t_field;

    // One input item
    typedef struct packed {
        logic       func;
        logic [7:0] rx_char;
    } t_item;

    // One result item
    typedef struct packed {
        logic       analog_mode;
        logic [6:0] seconds;
        logic [6:0] minutes;
        logic [6:0] hours;
    } t_time;

    // Restart a field at ten or more, then shift a decimal digit in (v*10 + d)
    function automatic logic [6:0] shift_digit(input logic [6:0] v, input logic [3:0] d);
        logic [6:0] base;
        base = (v >= DIGIT_LIMIT) ? 7'd0 : v;
        return 7'({base, 3'b000} + {base, 1'b0} + {3'b000, d});
    endfunction

endpackage

@@ rtl/serial_set_time_of_day_clock_core.sv @@
// 24-hour clock with serial time entry, one result per tick or character.
// This block takes one item every clock cycle while the output side takes results, and
// delivers its result after acceptance through the input register, then the result
// register. The rate is set by the time update, which closes its loop through the
// update unit, so items may follow each other without gaps while the output side takes
// them. An item with tuser low is a one-second tick; with tuser high its tdata is a
// received character (':' next field, '-' clear, a digit shifts into the field).
// Time after reset is 12:58:50 with analog mode selected.
// Depends on sstod_pkg, sstod_in_stage, sstod_core and the assertion macro header.
`include "serial_set_time_of_day_clock_core_macros.svh"

module serial_set_time_of_day_clock_core
    import sstod_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_char
    input  logic        i_s_axis_tuser,   // [0] func
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata    // [6:0] hours, [13:7] minutes,
                                          // [20:14] seconds, [21] analog_mode, [23:22] zero
);

    t_item w_in_item;
    t_item w_held_item;
    logic  w_held_valid;
    logic  w_advance;
    t_time w_next;

    logic  r_out_valid;
    logic  n_out_valid;
    t_time r_out;

    assign w_in_item.func    = i_s_axis_tuser;
    assign w_in_item.rx_char = i_s_axis_tdata;

    // Move the held item on when the result register is free or being emptied
    assign w_advance = w_held_valid && (!r_out_valid || i_m_axis_tready);

    sstod_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_item    (w_in_item),
        .o_ready   (o_s_axis_tready),
        .i_advance (w_advance),
        .o_valid   (w_held_valid),
        .o_item    (w_held_item)
    );

    sstod_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (w_held_item),
        .o_next    (w_next)
    );

    // Result register valid flag
    always_comb begin
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Load the updated time as the result
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_next;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out};

    // A moved item always leaves a result waiting in the next cycle
    `SSTOD_ASSERT_NEXT(a_advance_gives_result, w_advance, r_out_valid, "advanced item lost")
    // The input side never accepts into a full stage that is not moving on
    `SSTOD_ASSERT_SAME(a_no_overwrite, o_s_axis_tready, !w_held_valid || w_advance, "input stage overwritten")
    // Results never exceed two decimal digits
    `SSTOD_ASSERT_SAME(a_result_range, r_out_valid, r_out.hours <= 7'd99 && r_out.minutes <= 7'd99 && r_out.seconds <= 7'd99, "time field out of range")

endmodule

@@ rtl/sstod_in_stage.sv @@
// Input register for the serial-set time-of-day clock: holds one accepted item.
// Depends on sstod_pkg.
module sstod_in_stage
    import sstod_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_accept;

    // Take a new item when empty or when the held item moves on this cycle
    assign o_ready  = !r_valid || i_advance;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hold the payload until replaced
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/sstod_core.sv @@
// Time state and its update from one tick or one received character.
// Depends on sstod_pkg.
module sstod_core
    import sstod_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_advance,
    input  t_item i_item,
    output t_time o_next
);

    logic [6:0] r_hour;
    logic [6:0] r_min;
    logic [6:0] r_sec;
    t_field     r_field;
    logic [4:0] r_phase;
    logic       r_mode;

    logic [6:0] n_hour;
    logic [6:0] n_min;
    logic [6:0] n_sec;
    t_field     n_field;
    logic [4:0] n_phase;
    logic       n_mode;

    logic [6:0] w_sec_inc;
    logic [6:0] w_min_inc;
    logic [6:0] w_hour_inc;
    logic [4:0] w_phase_inc;
    logic [3:0] w_digit;
    logic       w_is_digit;

    assign w_sec_inc   = 7'(r_sec + 7'd1);
    assign w_min_inc   = 7'(r_min + 7'd1);
    assign w_hour_inc  = 7'(r_hour + 7'd1);
    assign w_phase_inc = 5'(r_phase + 5'd1);
    assign w_digit     = 4'(i_item.rx_char - CHAR_ZERO);
    assign w_is_digit  = (i_item.rx_char >= CHAR_ZERO) && (i_item.rx_char <= CHAR_NINE);

    // Work out the next time from the held item
    always_comb begin
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        n_field = r_field;
        n_phase = r_phase;
        n_mode  = r_mode;
        if (i_item.func == FUNC_TICK) begin
            // flip display mode every tenth tick
            if (r_phase == 5'd0 || r_phase == PHASE_FLIP) begin
                n_mode = !r_mode;
            end
            // advance seconds, carry into minutes and hours
            if (w_sec_inc >= SEC_LIMIT) begin
                n_sec = 7'd0;
                if (w_min_inc >= MIN_LIMIT) begin
                    n_min  = 7'd0;
                    n_hour = (w_hour_inc >= HOUR_LIMIT) ? 7'd0 : w_hour_inc;
                end else begin
                    n_min = w_min_inc;
                end
            end else begin
                n_sec = w_sec_inc;
            end
            n_phase = (w_phase_inc >= PHASE_LIMIT) ? 5'd0 : w_phase_inc;
        end else if (i_item.rx_char == CHAR_COLON) begin
            // step to the next field, stopping at seconds
            case (r_field)
                FIELD_HOUR: n_field = FIELD_MIN;
                FIELD_MIN:  n_field = FIELD_SEC;
                default:    n_field = FIELD_SEC;
            endcase
        end else if (i_item.rx_char == CHAR_DASH) begin
            // clear the time and return to hours
            n_hour  = 7'd0;
            n_min   = 7'd0;
            n_sec   = 7'd0;
            n_field = FIELD_HOUR;
        end else if (w_is_digit) begin
            // shift the digit into the selected field
            case (r_field)
                FIELD_HOUR: n_hour = shift_digit(r_hour, w_digit);
                FIELD_MIN:  n_min  = shift_digit(r_min, w_digit);
                default:    n_sec  = shift_digit(r_sec, w_digit);
            endcase
        end
    end

    // Commit the update when the item moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour  <= HOUR_RESET;
            r_min   <= MIN_RESET;
            r_sec   <= SEC_RESET;
            r_field <= FIELD_HOUR;
            r_phase <= 5'd0;
            r_mode  <= 1'b1;
        end else if (i_advance) begin
            r_hour  <= n_hour;
            r_min   <= n_min;
            r_sec   <= n_sec;
            r_field <= n_field;
            r_phase <= n_phase;
            r_mode  <= n_mode;
        end
    end

    assign o_next.hours       = n_hour;
    assign o_next.minutes     = n_min;
    assign o_next.seconds     = n_sec;
    assign o_next.analog_mode = n_mode;

endmodule

@@ dv/tb_serial_set_time_of_day_clock_core.sv @@
// Self-checking testbench for serial_set_time_of_day_clock_core: drives ticks and characters
// on the input stream and compares every result item with a predicted time of day.
// Depends on sstod_pkg and the RTL of the block; reads no files.
module tb_serial_set_time_of_day_clock_core;
    import sstod_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 300000;
    localparam int unsigned ITEMS_PER_PHASE = 450;

    // Predicts the clock and holds the times still owed by the block
    class time_of_day_scoreboard;
        logic [6:0] hour_now;
        logic [6:0] minute_now;
        logic [6:0] second_now;
        t_field     field_now;
        logic [4:0] phase_now;
        logic       analog_now;
        t_time      due_times[$];
        int unsigned failures;

        function new();
            hour_now   = HOUR_RESET;
            minute_now = MIN_RESET;
            second_now = SEC_RESET;
            field_now  = FIELD_HOUR;
            phase_now  = '0;
            analog_now = 1'b1;
            failures   = 0;
        endfunction

        // Restart a field that already has two digits, then append the new digit
        function logic [6:0] append_digit(input logic [6:0] v, input logic [3:0] d);
            int unsigned base;
            base = (v >= 7'd10) ? 0 : int'(v);
            return 7'(base * 10 + int'(d));
        endfunction

        function void advance_clock(input t_item it);
            logic [3:0] digit;
            if (it.func == FUNC_TICK) begin
                if (phase_now % PHASE_FLIP == 5'd0) analog_now = ~analog_now;
                second_now = second_now + 7'd1;
                if (second_now >= SEC_LIMIT) begin
                    second_now = '0;
                    minute_now = minute_now + 7'd1;
                    if (minute_now >= MIN_LIMIT) begin
                        minute_now = '0;
                        hour_now   = hour_now + 7'd1;
                        if (hour_now >= HOUR_LIMIT) hour_now = '0;
                    end
                end
                phase_now = phase_now + 5'd1;
                if (phase_now >= PHASE_LIMIT) phase_now = '0;
            end else if (it.rx_char == CHAR_COLON) begin
                // stop at the seconds field
                if (field_now == FIELD_HOUR) field_now = FIELD_MIN;
                else field_now = FIELD_SEC;
            end else if (it.rx_char == CHAR_DASH) begin
                hour_now   = '0;
                minute_now = '0;
                second_now = '0;
                field_now  = FIELD_HOUR;
            end else if (it.rx_char >= CHAR_ZERO && it.rx_char <= CHAR_NINE) begin
                digit = 4'(it.rx_char - CHAR_ZERO);
                case (field_now)
                    FIELD_HOUR: hour_now   = append_digit(hour_now, digit);
                    FIELD_MIN:  minute_now = append_digit(minute_now, digit);
                    default:    second_now = append_digit(second_now, digit);
                endcase
            end
        endfunction

        // Note an accepted input item and queue the time it must produce
        function void note_item(input t_item it);
            t_time want;
            advance_clock(it);
            want.hours       = hour_now;
            want.minutes     = minute_now;
            want.seconds     = second_now;
            want.analog_mode = analog_now;
            due_times.push_back(want);
        endfunction

        // Compare an accepted result item with the oldest owed time
        function void check_time(input t_time got);
            t_time want;
            if (due_times.size() == 0) begin
                $error("unexpected result item: %0d:%0d:%0d mode %0d",
                       got.hours, got.minutes, got.seconds, got.analog_mode);
                failures++;
                return;
            end
            want = due_times.pop_front();
            if (got.hours !== want.hours) begin
                $error("hours: expected %0d, got %0d", want.hours, got.hours);
                failures++;
            end
            if (got.minutes !== want.minutes) begin
                $error("minutes: expected %0d, got %0d", want.minutes, got.minutes);
                failures++;
            end
            if (got.seconds !== want.seconds) begin
                $error("seconds: expected %0d, got %0d", want.seconds, got.seconds);
                failures++;
            end
            if (got.analog_mode !== want.analog_mode) begin
                $error("analog_mode: expected %0d, got %0d", want.analog_mode,
                       got.analog_mode);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return due_times.size();
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = '0;    // [7:0] rx_char
    logic        i_s_axis_tuser  = 1'b0;  // [0] func
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;          // [6:0] hours, [13:7] minutes, [20:14] seconds,
                                          // [21] analog_mode, [23:22] zero

    time_of_day_scoreboard time_board = new();
    int unsigned gap_pct     = 0;
    int unsigned stall_pct   = 0;
    int unsigned items_sent  = 0;
    int unsigned cycle_count = 0;

    serial_set_time_of_day_clock_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Stall the result side at random
    initial begin
        forever begin
            @(negedge i_clk);
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Check every accepted result item
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            time_board.check_time(t_time'(o_m_axis_tdata[21:0]));
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one item, with random idle cycles ahead of it; call and return at a falling edge
    task automatic send_item(input logic func, input logic [7:0] ch);
        t_item it;
        while ($urandom_range(99) < gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= ch;
        i_s_axis_tuser  <= func;
        do @(posedge i_clk); while (!o_s_axis_tready);
        it.func    = func;
        it.rx_char = ch;
        time_board.note_item(it);
        // ignored characters do not count towards the run length
        if (func == FUNC_TICK || ch == CHAR_COLON || ch == CHAR_DASH ||
            (ch >= CHAR_ZERO && ch <= CHAR_NINE)) begin
            items_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic send_number(input int unsigned v);
        send_item(FUNC_CHAR, CHAR_ZERO + 8'(v / 10));
        send_item(FUNC_CHAR, CHAR_ZERO + 8'(v % 10));
    endtask

    // Clear, then enter hours, minutes and seconds as two digits each
    task automatic set_time(input int unsigned h, input int unsigned m, input int unsigned s);
        send_item(FUNC_CHAR, CHAR_DASH);
        send_number(h);
        send_item(FUNC_CHAR, CHAR_COLON);
        send_number(m);
        send_item(FUNC_CHAR, CHAR_COLON);
        send_number(s);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_item(FUNC_TICK, 8'($urandom));
    endtask

    // Hold the sender off until every owed result has come back
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (time_board.pending() != 0);
    endtask

    // One random burst: mostly clean time entries followed by ticks, some noise
    task automatic random_burst();
        int unsigned kind;
        int unsigned pick;
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2: begin
                set_time($urandom_range(23), $urandom_range(59), $urandom_range(59));
                send_ticks($urandom_range(1, 40));
            end
            3: begin
                // land close to midnight so the day wraps
                set_time(23, $urandom_range(58, 59), $urandom_range(50, 59));
                send_ticks($urandom_range(5, 80));
            end
            4, 5: send_ticks($urandom_range(1, 80));
            6: begin
                // broken entry: digits, colons and dashes in any order
                repeat ($urandom_range(1, 8)) begin
                    pick = $urandom_range(11);
                    if (pick < 10) send_item(FUNC_CHAR, CHAR_ZERO + 8'(pick));
                    else if (pick == 10) send_item(FUNC_CHAR, CHAR_COLON);
                    else send_item(FUNC_CHAR, CHAR_DASH);
                end
            end
            7: repeat ($urandom_range(1, 4)) send_item(FUNC_CHAR, 8'($urandom));
            8: begin
                // fields above their range, up to two digits
                set_time($urandom_range(99), $urandom_range(99), $urandom_range(99));
                send_ticks($urandom_range(1, 10));
            end
            default: repeat ($urandom_range(1, 6)) send_item(1'($urandom), 8'($urandom));
        endcase
    endtask

    // Reset, directed items, then three phases of random traffic
    initial begin
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    gap_pct   = 22;
                    stall_pct = 45;
                end
                1: begin
                    gap_pct   = 45;
                    stall_pct = 22;
                end
                default: begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
            endcase

            if (phase == 0) begin
                // tick straight after reset flips the display mode
                send_item(FUNC_TICK, 8'hFF);
                // characters that leave the time alone
                send_item(FUNC_CHAR, 8'h00);
                send_item(FUNC_CHAR, 8'hFF);
                send_item(FUNC_CHAR, CHAR_ZERO - 8'd1);
                send_item(FUNC_CHAR, CHAR_NINE + 8'd1);
                // hours and seconds above range, then colon at the seconds field
                set_time(99, 59, 75);
                send_item(FUNC_CHAR, CHAR_COLON);
                send_item(FUNC_TICK, 8'h00);
                // a third digit restarts the field
                send_item(FUNC_CHAR, CHAR_ZERO + 8'd1);
                send_item(FUNC_CHAR, CHAR_ZERO + 8'd2);
                send_item(FUNC_CHAR, CHAR_NINE);
                // end of day
                set_time(23, 59, 59);
                send_item(FUNC_TICK, 8'h5A);
            end

            while (items_sent < (phase + 1) * ITEMS_PER_PHASE) random_burst();

            if (phase == 0) drain_results();
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (time_board.failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/sstod_pkg.sv
rtl/sstod_in_stage.sv
rtl/sstod_core.sv
rtl/serial_set_time_of_day_clock_core.sv
dv/tb_serial_set_time_of_day_clock_core.sv
